>>> rtl/core/cil_pkg.sv
// ----------------------------------------------------------------------------
// cil_pkg
// Shared types, codes and field widths for the compacted ID list table.
// ----------------------------------------------------------------------------
package cil_pkg;

  // Default geometry
  localparam int DEPTH_DEF    = 32;
  localparam int ID_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int OP_W       = 3;
  localparam int FID_W      = 16;
  localparam int POS_W      = 5;
  localparam int ST_W       = 2;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MARKER = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    RES_NOP,
    RES_CLEAR,
    RES_APPEND,
    RES_FULL,
    RES_DEL_OK,
    RES_FOUND,
    RES_NOT_FOUND,
    RES_READ_MEM,
    RES_READ_MARK,
    RES_RANGE
  } res_t;

  typedef struct packed {
    logic load_in;
    logic scan_start;
    logic scan_step;
    logic take_hit;
    logic shift_en;
    logic read_pos;
    logic done;
    res_t res;
  } cil_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            append_ok;
    logic            del_marker;
    logic            rd_range;
    logic            rd_used;
    logic            hit;
    logic            scan_end;
    logic            can_load;
  } cil_stat_t;

endpackage

>>> rtl/core/cil_ctrl.sv
// ----------------------------------------------------------------------------
// cil_ctrl
// Sequencer: decodes each beat, runs the slot scan and shift, loads results.
// ----------------------------------------------------------------------------
module cil_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cil_pkg::cil_stat_t stat,
  output cil_pkg::cil_cmd_t  cmd
);
  import cil_pkg::*;

  state_t state_r, state_nxt;
  res_t   kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= RES_NOP;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.res   = kind_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        unique case (stat.op)
          OP_CLEAR:  kind_nxt = RES_CLEAR;
          OP_APPEND: kind_nxt = stat.append_ok ? RES_APPEND : RES_FULL;
          OP_DELETE: begin
            if (stat.del_marker) begin
              kind_nxt = RES_NOT_FOUND;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          OP_FIND: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          OP_READ: begin
            priority if (stat.rd_range) begin
              kind_nxt = RES_RANGE;
            end else if (stat.rd_used) begin
              cmd.read_pos = 1'b1;
              kind_nxt     = RES_READ_MEM;
            end else begin
              kind_nxt = RES_READ_MARK;
            end
          end
          default: kind_nxt = RES_NOP;
        endcase
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          cmd.take_hit = 1'b1;
          if (stat.op == OP_DELETE) begin
            // keep the read pipe running into the shift
            cmd.scan_step = 1'b1;
            state_nxt     = S_SHIFT;
          end else begin
            kind_nxt  = RES_FOUND;
            state_nxt = S_FINISH;
          end
        end else if (stat.scan_end) begin
          kind_nxt  = RES_NOT_FOUND;
          state_nxt = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift_en = 1'b1;
        if (stat.scan_end) begin
          kind_nxt  = RES_DEL_OK;
          state_nxt = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.can_load) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/cil_datapath.sv
// ----------------------------------------------------------------------------
// cil_datapath
// Slot memory, scan pipeline, count and configuration registers, result beat.
// ----------------------------------------------------------------------------
module cil_datapath #(
  parameter int DEPTH    = cil_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = cil_pkg::ID_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [cil_pkg::OP_W-1:0]         in_op,
  input  logic [cil_pkg::FID_W-1:0]        in_id_value,
  input  logic [cil_pkg::POS_W-1:0]        in_position_in,
  input  logic                             cfg_we,
  input  logic [cil_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cil_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  cil_pkg::cil_cmd_t                cmd,
  output cil_pkg::cil_stat_t               stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [cil_pkg::ST_W-1:0]         out_status,
  output logic [cil_pkg::POS_W-1:0]        out_position,
  output logic [cil_pkg::FID_W-1:0]        out_id_out,
  output logic [cil_pkg::CNT_W-1:0]        out_count
);
  import cil_pkg::*;

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW      = CNT_W + 1;
  localparam int CAP_LIM = (1 << CNT_W) - 1;
  localparam int CAP_MAX = (DEPTH > CAP_LIM) ? CAP_LIM : DEPTH;

  // Configuration
  logic [CNT_W-1:0]    cap_r;
  logic [FID_W-1:0]    marker_r;
  logic [CNT_W-1:0]    eff_cap;
  logic [CNT_W-1:0]    new_eff;
  logic [ID_WIDTH-1:0] marker_m;

  // Latched item
  logic [OP_W-1:0]     op_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [POS_W-1:0]    pos_r;

  // Count and scan pipeline
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IW-1:0]       idx_r;
  logic [IW-1:0]       vidx_r;
  logic                vld_r;
  logic [IW-1:0]       where_r;
  logic [IW-1:0]       step_idx;

  // Memory
  logic [ID_WIDTH-1:0] mem [DEPTH];
  logic [ID_WIDTH-1:0] rdata_r;
  logic                re;
  logic [AW-1:0]       raddr;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [ID_WIDTH-1:0] wdata;

  // Result
  logic                out_valid_r;
  logic [ST_W-1:0]     status_r, status_nxt;
  logic [POS_W-1:0]    position_r, position_nxt;
  logic [FID_W-1:0]    id_out_r, id_out_nxt;

  assign eff_cap  = (cap_r > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX) : cap_r;
  assign new_eff  = (cfg_data[CNT_W-1:0] > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX)
                                                           : cfg_data[CNT_W-1:0];
  assign marker_m = ID_WIDTH'(marker_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CNT_W'(32);
      marker_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPACITY:     cap_r    <= cfg_data[CNT_W-1:0];
        REG_EMPTY_MARKER: marker_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_op;
      id_r  <= ID_WIDTH'(in_id_value);
      pos_r <= in_position_in;
    end
  end

  // Scan pipe: issue one slot read per step, compare it the next cycle
  assign step_idx = cmd.scan_start ? '0 : idx_r;
  assign re       = cmd.scan_start | cmd.scan_step | cmd.read_pos;
  assign raddr    = cmd.read_pos ? AW'(pos_r) : AW'(step_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (cmd.scan_start || cmd.scan_step) begin
      vld_r <= step_idx < IW'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start || cmd.scan_step) begin
      vidx_r <= step_idx;
      idx_r  <= step_idx + IW'(1);
    end
    if (cmd.take_hit) begin
      where_r <= vidx_r;
    end
  end

  // One write port: shift a slot down, or append at the end
  always_comb begin
    we    = 1'b0;
    waddr = AW'(count_r);
    wdata = id_r;
    if (cmd.shift_en && vld_r) begin
      we    = 1'b1;
      waddr = AW'(vidx_r - IW'(1));
      wdata = rdata_r;
    end else if (cmd.done && cmd.res == RES_APPEND) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Status to the sequencer
  always_comb begin
    stat            = '0;
    stat.op         = op_r;
    stat.append_ok  = count_r < eff_cap;
    stat.del_marker = id_r == marker_m;
    stat.rd_range   = {1'b0, pos_r} >= eff_cap;
    stat.rd_used    = {1'b0, pos_r} < count_r;
    stat.hit        = vld_r && (rdata_r == id_r);
    stat.scan_end   = !vld_r;
    stat.can_load   = !out_valid_r || out_ready;
  end

  // Count update and result beat
  always_comb begin
    count_nxt    = count_r;
    status_nxt   = ST_OK;
    position_nxt = '0;
    id_out_nxt   = '0;
    if (cfg_we && cfg_index == REG_CAPACITY) begin
      if (count_r > new_eff) begin
        count_nxt = new_eff;
      end
    end else if (cmd.done) begin
      unique case (cmd.res)
        RES_CLEAR: count_nxt = '0;
        RES_APPEND: begin
          position_nxt = POS_W'(count_r);
          count_nxt    = count_r + CNT_W'(1);
        end
        RES_FULL:      status_nxt = ST_FULL;
        RES_DEL_OK: begin
          position_nxt = POS_W'(where_r);
          count_nxt    = count_r - CNT_W'(1);
        end
        RES_FOUND:     position_nxt = POS_W'(where_r);
        RES_NOT_FOUND: status_nxt = ST_NOT_FOUND;
        RES_READ_MEM:  id_out_nxt = FID_W'(rdata_r);
        RES_READ_MARK: id_out_nxt = FID_W'(marker_m);
        RES_RANGE:     status_nxt = ST_RANGE;
        default:       status_nxt = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      status_r   <= status_nxt;
      position_r <= position_nxt;
      id_out_r   <= id_out_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_position = position_r;
  assign out_id_out   = id_out_r;
  assign out_count    = count_r;

endmodule

>>> rtl/core/compacted_id_list_table.sv
// ----------------------------------------------------------------------------
// compacted_id_list_table
// Packed identifier list with append, shift-on-delete, find, read and clear.
// ----------------------------------------------------------------------------
// Sequence: each beat is latched in idle, decoded, then loaded as the result in
//   finish once the output can take it; find, and delete of any ID but the
//   marker, first scan the slots up to a hit or the count; delete then shifts every later slot down.
// Throughput: one item at a time, bound by the slot scan (one slot a
//   cycle); a new beat is taken the cycle after the result is loaded.
// Reset: count clears to zero, capacity to 32, empty marker to zero. No slot
//   clearing pass: slots at or above count are never taken from memory as results.
// ----------------------------------------------------------------------------
module compacted_id_list_table #(
  parameter int DEPTH    = cil_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = cil_pkg::ID_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: op[2:0], id_value[18:3], position_in[23:19]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cil_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: status[1:0], position[6:2], id_out[22:7], count[28:23], zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cil_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Configuration writes: index 0 capacity, index 1 empty marker
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cil_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cil_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cil_pkg::*;

  cil_cmd_t         cmd;
  cil_stat_t        stat;
  logic [ST_W-1:0]  res_status;
  logic [POS_W-1:0] res_position;
  logic [FID_W-1:0] res_id_out;
  logic [CNT_W-1:0] res_count;

  // Registers always writable; the user must only send writes while the list is idle, not enforced
  assign cfg_ready = 1'b1;

  cil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cil_datapath #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_tdata[2:0]),
    .in_id_value    (in_tdata[18:3]),
    .in_position_in (in_tdata[23:19]),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_status     (res_status),
    .out_position   (res_position),
    .out_id_out     (res_id_out),
    .out_count      (res_count)
  );

  // Pack the result beat, lowest field first, pad to a whole byte
  assign out_tdata = {3'b000, res_count, res_id_out, res_position, res_status};

endmodule

>>> test/compacted_id_list_table_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacted_id_list_table_check
// Watches the config, input and result streams of the ID list table, keeps
// its own copy of the list and compares every result beat field by field.
// ----------------------------------------------------------------------------
module compacted_id_list_table_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [cil_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [cil_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [cil_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cil_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding,
  output int                             results_seen
);
  import cil_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
    logic [FID_W-1:0] id_out;
    logic [CNT_W-1:0] count;
  } list_result_t;

  logic [FID_W-1:0] slot_mem [DEPTH_DEF];
  int               fill;
  logic [CNT_W-1:0] cap_reg;
  logic [FID_W-1:0] marker;
  list_result_t     result_q [$];
  int               err_n;
  int               seen_n;

  function automatic int usable_slots();
    return (cap_reg > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg);
  endfunction

  // Apply one operation to the list copy and return what the block must report.
  function automatic list_result_t apply_op(logic [OP_W-1:0] op, logic [FID_W-1:0] id,
                                            logic [POS_W-1:0] slot);
    list_result_t r;
    int           hit;
    int           lim;
    r   = '0;
    hit = -1;
    lim = usable_slots();
    for (int i = 0; i < fill; i++)
      if (hit < 0 && slot_mem[i] == id) hit = i;
    case (op)
      OP_CLEAR: fill = 0;
      OP_APPEND: begin
        if (fill < lim) begin
          slot_mem[fill] = id;
          r.position     = POS_W'(fill);
          fill++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        // the marker value is never removable, even when it was appended
        if (id != marker && hit >= 0) begin
          for (int i = hit; i + 1 < fill; i++) slot_mem[i] = slot_mem[i + 1];
          fill--;
          r.position = POS_W'(hit);
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_FIND: begin
        if (hit >= 0) r.position = POS_W'(hit);
        else r.status = ST_NOT_FOUND;
      end
      OP_READ: begin
        if (slot >= lim) r.status = ST_RANGE;
        else if (slot < fill) r.id_out = slot_mem[slot];
        else r.id_out = marker;
      end
      default: ;
    endcase
    r.count = CNT_W'(fill);
    return r;
  endfunction

  task automatic check_field(string name, logic [FID_W-1:0] want, logic [FID_W-1:0] got);
    if (got !== want) begin
      err_n++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      fill    = 0;
      cap_reg = CNT_W'(DEPTH_DEF);
      marker  = '0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CAPACITY) begin
          cap_reg = cfg_data[CNT_W-1:0];
          if (fill > usable_slots()) fill = usable_slots();
        end else begin
          marker = cfg_data;
        end
      end
      if (out_tvalid && out_tready) begin
        seen_n++;
        if (result_q.size() == 0) begin
          err_n++;
          $display("%0t: result beat with nothing expected, actual 0x%0h", $time, out_tdata);
        end else begin
          want = result_q.pop_front();
          check_field("status",   FID_W'(want.status),   FID_W'(out_tdata[1:0]));
          check_field("position", FID_W'(want.position), FID_W'(out_tdata[6:2]));
          check_field("id_out",   want.id_out,           out_tdata[22:7]);
          check_field("count",    FID_W'(want.count),    FID_W'(out_tdata[28:23]));
        end
      end
      if (in_tvalid && in_tready)
        result_q.push_back(apply_op(in_tdata[2:0], in_tdata[18:3], in_tdata[23:19]));
    end
    outstanding  <= result_q.size();
    mismatches   <= err_n;
    results_seen <= seen_n;
  end

endmodule

>>> test/compacted_id_list_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacted_id_list_table_test
// Drives the ID list table with directed and random operations over several
// capacity and marker settings, with random gaps on the input and back-pressure on the result stream.
// ----------------------------------------------------------------------------
module compacted_id_list_table_test;
  import cil_pkg::*;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // in_tdata: op[2:0], id_value[18:3], position_in[23:19]
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata: status[1:0], position[6:2], id_out[22:7], count[28:23], zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int mismatches;
  int outstanding;
  int results_seen;

  // Stimulus knobs shared with the result-side process
  bit               steady_mode  = 1'b0;  // no idling on either side
  bit               hold_request = 1'b0;  // ask the receiver for one long hold-off
  int               beats_sent   = 0;
  int               settings_run = 0;
  logic [FID_W-1:0] marker_now   = '0;
  logic [FID_W-1:0] id_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  compacted_id_list_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  compacted_id_list_table_check checker_inst (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  // Mostly back-to-back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_mode || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one beat and hold it until the block takes it. Valid is lowered only
  // ahead of a gap so it never drops and rises within one time step.
  task automatic push_op(logic [OP_W-1:0] op, logic [FID_W-1:0] id, logic [POS_W-1:0] slot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {slot, id, op};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Stop offering and wait until every expected result beat has arrived.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_EMPTY_MARKER) marker_now = val;
  endtask

  // Idle the block, load a new capacity and marker, and refresh the ID pool so
  // that duplicates and hits stay frequent in the random traffic.
  task automatic load_setting(logic [CNT_W-1:0] cap, logic [FID_W-1:0] mark);
    drain();
    write_reg(REG_CAPACITY, CFG_DATA_W'(cap));
    write_reg(REG_EMPTY_MARKER, mark);
    settings_run++;
    id_pool[0] = mark;
    id_pool[1] = ~mark;
    for (int i = 2; i < 8; i++) id_pool[i] = FID_W'($urandom);
  endtask

  task automatic random_op();
    int               r;
    logic [OP_W-1:0]  op;
    logic [FID_W-1:0] id;
    logic [POS_W-1:0] slot;
    r = $urandom_range(0, 99);
    if (r < 2) op = OP_CLEAR;
    else if (r < 40) op = OP_APPEND;
    else if (r < 60) op = OP_DELETE;
    else if (r < 78) op = OP_FIND;
    else if (r < 95) op = OP_READ;
    else op = OP_W'(OP_READ + $urandom_range(1, 3));  // undefined codes
    r = $urandom_range(0, 99);
    if (r < 70) id = id_pool[$urandom_range(0, 7)];
    else if (r < 80) id = marker_now;
    else id = FID_W'($urandom);
    slot = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 7)) : POS_W'($urandom);
    push_op(op, id, slot);
  endtask

  // Result side: random ready pattern, one long hold-off on request.
  initial begin
    int n;
    int r;
    forever begin
      if (hold_request) begin
        out_tready   <= 1'b0;
        n            = 400;
        hold_request = 1'b0;
      end else if (steady_mode) begin
        out_tready <= 1'b1;
        n          = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_tready <= 1'b1;
          n          = $urandom_range(1, 6);
        end else if (r < 92) begin
          out_tready <= 1'b0;
          n          = $urandom_range(1, 3);
        end else begin
          out_tready <= 1'b0;
          n          = $urandom_range(10, 40);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    int                caps [9];
    logic [FID_W-1:0]  marks [9];
    caps  = '{32, 63, 1, 0, 5, 17, 33, 40, 32};
    marks = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE, 16'h0000, 16'h0000, 16'h0000,
              16'h0000, 16'h0000};
    for (int k = 4; k < 9; k++) marks[k] = FID_W'($urandom);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, duplicates, marker as an ID, unknown codes.
    push_op(OP_READ,   16'h0000, 5'd0);
    push_op(OP_READ,   16'h0000, 5'd31);
    push_op(OP_FIND,   16'h0000, 5'd0);
    push_op(OP_DELETE, 16'h0000, 5'd0);
    push_op(OP_APPEND, 16'hFFFF, 5'd0);
    push_op(OP_APPEND, 16'h0000, 5'd0);
    push_op(OP_APPEND, 16'h1234, 5'd0);
    push_op(OP_APPEND, 16'h1234, 5'd0);
    push_op(OP_APPEND, 16'hABCD, 5'd0);
    push_op(OP_FIND,   16'h0000, 5'd0);
    push_op(OP_DELETE, 16'h0000, 5'd0);
    push_op(OP_DELETE, 16'h1234, 5'd0);
    push_op(OP_FIND,   16'h1234, 5'd0);
    push_op(OP_DELETE, 16'h7777, 5'd0);
    push_op(OP_READ,   16'h0000, 5'd1);
    push_op(OP_READ,   16'h0000, 5'd4);
    for (int k = 1; k <= 3; k++) push_op(OP_W'(OP_READ + k), 16'hFFFF, 5'd31);
    push_op(OP_CLEAR,  16'h0000, 5'd0);

    // Zero capacity: nothing fits, nothing is readable.
    load_setting(6'd0, 16'h0000);
    push_op(OP_APPEND, 16'h00FF, 5'd0);
    push_op(OP_READ,   16'h0000, 5'd0);
    // Small capacity: fill up, overflow, read past the end.
    load_setting(6'd3, 16'h5A5A);
    for (int k = 0; k < 4; k++) push_op(OP_APPEND, FID_W'($urandom), 5'd0);
    push_op(OP_READ,   16'h0000, 5'd2);
    push_op(OP_READ,   16'h0000, 5'd3);
    // Capacity above the depth saturates; then shrink below the count.
    load_setting(6'd40, 16'h5A5A);
    push_op(OP_APPEND, 16'hC3C3, 5'd0);
    push_op(OP_APPEND, 16'h3C3C, 5'd0);
    load_setting(6'd2, 16'hA5A5);
    push_op(OP_FIND,   16'hC3C3, 5'd0);
    push_op(OP_READ,   16'h0000, 5'd1);
    push_op(OP_READ,   16'h0000, 5'd2);

    // Random phases, one per setting.
    for (int k = 0; k < 9; k++) begin
      load_setting(CNT_W'(caps[k]), marks[k]);
      steady_mode = (k == 2 || k == 6);
      if (k == 0) begin
        // fill the whole list and run one append past full
        push_op(OP_CLEAR, marker_now, 5'd0);
        for (int i = 0; i <= DEPTH_DEF; i++) push_op(OP_APPEND, id_pool[$urandom_range(1, 7)],
                                                     5'd0);
        for (int i = 0; i < 32; i++) push_op(OP_READ, marker_now, POS_W'(i));
        // stall the result side for a long stretch while input keeps coming
        hold_request = 1'b1;
        for (int i = 0; i < 30; i++) random_op();
      end
      for (int i = 0; i < 65; i++) begin
        random_op();
        if (k == 3 && i == 30) drain();
      end
    end
    steady_mode = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d operation beats over %0d capacity/marker settings;", beats_sent,
             settings_run);
    $display("compared %0d result beats, with long stalls on both streams.", results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
